// File: rtl/core/dpsm_pkg.sv
// Shared types and constants for the dual-channel pulse-skip modulator.
// No dependencies; imported by every module in rtl/core.
`timescale 1ns / 1ps

package dpsm_pkg;

    localparam int RANGE_W = 16;
    localparam int DIV_W   = 8;
    localparam int CNT_W   = 31;
    localparam int TS_W    = 32;
    localparam int GAP_W   = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 31;
    localparam int IN_DATA_W  = 32;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 72;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    typedef enum logic [1:0] {
        OP_CROSSING  = 2'd0,
        OP_TIMER     = 2'd1,
        OP_CLEAR_ONE = 2'd2,
        OP_CLEAR_TWO = 2'd3
    } op_e_t;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RANGE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DUTY_ONE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DUTY_TWO   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DIV_ONE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DIV_TWO    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT_ONE  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT_TWO  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_GAP        = 3'd7;

    typedef struct packed {
        logic [RANGE_W-1:0] duty;
        logic [DIV_W-1:0]   divider;
        logic [CNT_W-1:0]   limit;
    } chan_cfg_t;

    typedef struct packed {
        logic crossing;   // accepted zero crossing, committed this cycle
        logic clear;      // zero the fire counter
    } chan_ctrl_t;

    typedef struct packed {
        logic             skip;   // skip flag after this request
        logic [CNT_W-1:0] fires;  // fire count after this request
    } chan_stat_t;

endpackage

// File: rtl/core/dual_pulse_skip_modulator_core.sv
// Top level of the two-channel pulse-skip modulator.
// Depends on dpsm_pkg, dpsm_gap_filter and dpsm_channel.
`timescale 1ns / 1ps

// Usage:
//   Slave stream carries event requests: s_tuser = operation (zero crossing,
//   timer expiry, clear counter one, clear counter two), s_tdata = ms timestamp.
//   Every request yields exactly one result on the master stream: both drive
//   levels, both fire counts and the crossing-rejected flag.
//   Config port: cfg_we/cfg_index/cfg_data writes one register per cycle;
//   write only while no request is in flight.
// Timing:
//   Requests land in an input register, the channel and filter logic computes
//   the update from it, and the result is held in an output register. One
//   request per cycle sustained while m_tready keeps the output draining; the
//   channel accumulators update as each request advances, which sets that rate.
// Reset:
//   Accumulators, counters, levels and last crossing time clear to zero;
//   range resets to 100, dividers to 1, other config registers to 0. Both streams idle.
// Backpressure:
//   When m_tready is low the result holds; the input register still takes one
//   more request, then s_tready drops until the output drains. Nothing is lost.

module dual_pulse_skip_modulator_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // slave stream
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [dpsm_pkg::IN_DATA_W-1:0]       s_tdata,   // [31:0] timestamp_ms
    input  logic [dpsm_pkg::IN_USER_W-1:0]       s_tuser,   // [1:0] operation
    // master stream
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [dpsm_pkg::OUT_DATA_W-1:0]      m_tdata,   // [0] drive_one, [1] drive_two,
                                                            // [32:2] fires_one,
                                                            // [63:33] fires_two,
                                                            // [64] crossing_ignored,
                                                            // [71:65] zero
    // config write port
    input  logic                                 cfg_we,
    input  logic [dpsm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [dpsm_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import dpsm_pkg::*;

    // configuration registers
    logic [RANGE_W-1:0] range_reg;
    logic [RANGE_W-1:0] duty_one_reg, duty_two_reg;
    logic [DIV_W-1:0]   div_one_reg, div_two_reg;
    logic [CNT_W-1:0]   limit_one_reg, limit_two_reg;
    logic [GAP_W-1:0]   gap_reg;

    // input stage
    logic               in_valid_reg, in_valid_next;
    op_e_t              op_reg;
    logic [TS_W-1:0]    ts_reg;

    // output stage
    logic               out_valid_reg, out_valid_next;
    logic               drive_one_reg, drive_two_reg;
    logic [CNT_W-1:0]   fires_one_reg, fires_two_reg;
    logic               ignored_reg;

    // levels
    logic               level_one_reg, level_one_next;
    logic               level_two_reg, level_two_next;

    logic               s_accept;
    logic               advance;
    logic               is_cross;
    logic               gap_hit;
    logic               cross_ok;
    chan_cfg_t          cfg_one, cfg_two;
    chan_ctrl_t         ctrl_one, ctrl_two;
    chan_stat_t         stat_one, stat_two;

    // result moves out of the input stage when the output register is free
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    assign is_cross = (op_reg == OP_CROSSING);
    assign cross_ok = advance && is_cross && !gap_hit;

    dpsm_gap_filter u_gap (
        .clk     (clk),
        .rst_n   (rst_n),
        .gap     (gap_reg),
        .ts      (ts_reg),
        .en      (advance && is_cross),
        .ignored (gap_hit)
    );

    assign cfg_one = '{duty: duty_one_reg, divider: div_one_reg, limit: limit_one_reg};
    assign cfg_two = '{duty: duty_two_reg, divider: div_two_reg, limit: limit_two_reg};

    assign ctrl_one = '{crossing: cross_ok, clear: advance && (op_reg == OP_CLEAR_ONE)};
    assign ctrl_two = '{crossing: cross_ok, clear: advance && (op_reg == OP_CLEAR_TWO)};

    dpsm_channel u_chan_one (
        .clk   (clk),
        .rst_n (rst_n),
        .range (range_reg),
        .cfg   (cfg_one),
        .ctrl  (ctrl_one),
        .stat  (stat_one)
    );

    dpsm_channel u_chan_two (
        .clk   (clk),
        .rst_n (rst_n),
        .range (range_reg),
        .cfg   (cfg_two),
        .ctrl  (ctrl_two),
        .stat  (stat_two)
    );

    always_comb
    begin
        level_one_next = level_one_reg;
        level_two_next = level_two_reg;
        if (cross_ok)
        begin
            level_one_next = !stat_one.skip;
            level_two_next = !stat_two.skip;
        end
        else if (advance && op_reg == OP_TIMER)
        begin
            // timer expiry forces channel one off, channel two follows its flag
            level_one_next = 1'b0;
            level_two_next = !stat_two.skip;
        end

        if (s_accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
        else
        begin
            in_valid_next = in_valid_reg;
        end

        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // control and state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            level_one_reg <= 1'b0;
            level_two_reg <= 1'b0;
            range_reg     <= 16'd100;
            duty_one_reg  <= '0;
            duty_two_reg  <= '0;
            div_one_reg   <= 8'd1;
            div_two_reg   <= 8'd1;
            limit_one_reg <= '0;
            limit_two_reg <= '0;
            gap_reg       <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            level_one_reg <= level_one_next;
            level_two_reg <= level_two_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_RANGE:     range_reg     <= cfg_data[RANGE_W-1:0];
                    REG_DUTY_ONE:  duty_one_reg  <= cfg_data[RANGE_W-1:0];
                    REG_DUTY_TWO:  duty_two_reg  <= cfg_data[RANGE_W-1:0];
                    REG_DIV_ONE:   div_one_reg   <= cfg_data[DIV_W-1:0];
                    REG_DIV_TWO:   div_two_reg   <= cfg_data[DIV_W-1:0];
                    REG_LIMIT_ONE: limit_one_reg <= cfg_data[CNT_W-1:0];
                    REG_LIMIT_TWO: limit_two_reg <= cfg_data[CNT_W-1:0];
                    REG_GAP:       gap_reg       <= cfg_data[GAP_W-1:0];
                    default:       ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            op_reg <= op_e_t'(s_tuser);
            ts_reg <= s_tdata[TS_W-1:0];
        end
        if (advance)
        begin
            drive_one_reg <= level_one_next;
            drive_two_reg <= level_two_next;
            fires_one_reg <= stat_one.fires;
            fires_two_reg <= stat_two.fires;
            ignored_reg   <= is_cross && gap_hit;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, ignored_reg, fires_two_reg, fires_one_reg,
                       drive_two_reg, drive_one_reg};

endmodule

// File: rtl/core/dpsm_gap_filter.sv
// Zero-crossing debounce: rejects crossings closer than the minimum gap.
// Depends on dpsm_pkg.
`timescale 1ns / 1ps

module dpsm_gap_filter (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [dpsm_pkg::GAP_W-1:0] gap,
    input  logic [dpsm_pkg::TS_W-1:0]  ts,
    input  logic                      en,
    output logic                      ignored
);
    import dpsm_pkg::*;

    logic [TS_W-1:0] last_reg;
    logic [TS_W-1:0] ts_minus_gap;

    assign ts_minus_gap = ts - {{(TS_W-GAP_W){1'b0}}, gap};
    assign ignored = (gap != '0) && (ts_minus_gap < last_reg) && (ts >= last_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg <= '0;
        end
        else if (en && !ignored)
        begin
            last_reg <= ts;
        end
    end

endmodule

// File: rtl/core/dpsm_channel.sv
// One modulator channel: period divider, phase accumulator, fire counter.
// Depends on dpsm_pkg.
`timescale 1ns / 1ps

module dpsm_channel (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [dpsm_pkg::RANGE_W-1:0]  range,
    input  dpsm_pkg::chan_cfg_t           cfg,
    input  dpsm_pkg::chan_ctrl_t          ctrl,
    output dpsm_pkg::chan_stat_t          stat
);
    import dpsm_pkg::*;

    logic [RANGE_W-1:0] acc_reg, acc_next;
    logic               skip_reg, skip_next;
    logic [DIV_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   fires_reg, fires_next;

    logic [DIV_W-1:0]   dm1;
    logic               tick;
    logic [DIV_W-1:0]   count_adv;
    logic [RANGE_W-1:0] duty_c;
    logic [RANGE_W:0]   sum;
    logic [RANGE_W:0]   wrapped;
    logic               fire_raw;
    logic [CNT_W-1:0]   fires_inc;
    logic               skip_eval;

    always_comb
    begin
        dm1       = (cfg.divider == '0) ? '0 : cfg.divider - {{(DIV_W-1){1'b0}}, 1'b1};
        tick      = count_reg >= dm1;
        count_adv = tick ? count_reg - dm1 : count_reg + {{(DIV_W-1){1'b0}}, 1'b1};

        duty_c = (cfg.duty < range) ? cfg.duty : range;
        sum    = {1'b0, acc_reg} + {1'b0, duty_c};
        if (sum >= {1'b0, range})
        begin
            wrapped  = sum - {1'b0, range};
            fire_raw = 1'b1;
        end
        else
        begin
            wrapped  = sum;
            fire_raw = 1'b0;
        end
        // range lowered below the accumulator: restart from zero and fire
        if (wrapped > {1'b0, range})
        begin
            wrapped  = '0;
            fire_raw = 1'b1;
        end

        fires_inc = (fire_raw && fires_reg != CNT_MAX)
                    ? fires_reg + {{(CNT_W-1){1'b0}}, 1'b1} : fires_reg;
        skip_eval = !fire_raw || ((cfg.limit != '0) && (fires_inc > cfg.limit));

        acc_next   = acc_reg;
        skip_next  = skip_reg;
        count_next = count_reg;
        fires_next = fires_reg;
        if (ctrl.crossing)
        begin
            count_next = count_adv;
            if (tick)
            begin
                acc_next   = wrapped[RANGE_W-1:0];
                skip_next  = skip_eval;
                fires_next = fires_inc;
            end
        end
        if (ctrl.clear)
        begin
            fires_next = '0;
        end
    end

    assign stat.skip  = skip_next;
    assign stat.fires = fires_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg   <= '0;
            skip_reg  <= 1'b0;
            count_reg <= '0;
            fires_reg <= '0;
        end
        else
        begin
            acc_reg   <= acc_next;
            skip_reg  <= skip_next;
            count_reg <= count_next;
            fires_reg <= fires_next;
        end
    end

endmodule
